// ===== rtl/itp_pkg.sv =====
package itp_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;

  localparam int CMD_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    K_LETTER,
    K_OPEN,
    K_CLOSE,
    K_OPER
  } sym_kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_OPEN,
    ST_FULL
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CLOSE_EVAL,
    S_CLOSE_WAIT,
    S_CLOSE_MARK,
    S_OP_EVAL,
    S_OP_WAIT,
    S_PUSH,
    S_FLUSHCHK,
    S_FLUSH_WAIT,
    S_FLUSH_EVAL,
    S_FIN
  } back_state_t;

  typedef struct packed {
    sym_kind_t  kind;
    logic [7:0] sym;
    logic [1:0] prec;
    logic       last;
  } cmd_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c inside {CH_PLUS, CH_MINUS}) begin
      p = 2'd1;
    end else if (c inside {CH_STAR, CH_SLASH}) begin
      p = 2'd2;
    end
    return p;
  endfunction

endpackage

// ===== rtl/itp_front.sv =====
module itp_front
  import itp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_sym,
  input  logic       in_last,
  output logic       push_valid,
  input  logic       push_ready,
  output cmd_t       push_data
);

  logic fr_valid_r;
  cmd_t fr_cmd_r;
  cmd_t cls;
  logic accept;

  always_comb begin
    cls.sym  = in_sym;
    cls.last = in_last;
    cls.prec = prec_of(in_sym);
    if (in_sym inside {[CH_A:CH_Z]}) begin
      cls.kind = K_LETTER;
    end else if (in_sym == CH_OPEN) begin
      cls.kind = K_OPEN;
    end else if (in_sym == CH_CLOSE) begin
      cls.kind = K_CLOSE;
    end else begin
      cls.kind = K_OPER;
    end
  end

  assign in_tready  = !fr_valid_r || push_ready;
  assign accept     = in_tvalid && in_tready;
  assign push_valid = fr_valid_r;
  assign push_data  = fr_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (accept) begin
      fr_valid_r <= 1'b1;
    end else if (push_ready) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd_r <= cls;
    end
  end

endmodule

// ===== rtl/itp_cmd_queue.sv =====
module itp_cmd_queue
  import itp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
  localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t             q_mem_r [CMD_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = cnt_r != CNT_W'(CMD_QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = q_mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/itp_back.sv =====
module itp_back
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  cmd_t       q_data,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_sym,
  output logic       out_sym_valid,
  output logic       out_run_last,
  output logic       out_expr_end,
  output status_t    out_status
);

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [7:0]       stack_mem [STACK_DEPTH];
  logic [7:0]       rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;

  back_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t             cmd_r, cmd_nxt;

  logic             pend_valid_r;
  logic [7:0]       pend_sym_r;
  logic             pend_sv_r;
  status_t          pend_st_r;

  logic             out_valid_r;
  logic [7:0]       out_sym_r;
  logic             out_sv_r;
  logic             out_rlast_r;
  logic             out_eend_r;
  status_t          out_st_r;

  logic             emit_req;
  logic [7:0]       emit_sym;
  logic             emit_sv;
  status_t          emit_st;
  logic             emit_fire;
  logic             fin_move;
  logic             fin_mark;
  logic             out_free;
  logic             can_emit;
  logic             out_load_pend;
  logic             cnt_zero;
  logic             cnt_one;
  logic             cnt_full;
  logic [1:0]       top_prec;

  assign rd_addr  = AW'(cnt_r - 1'b1);
  assign out_free = !out_valid_r || out_tready;
  assign can_emit = !pend_valid_r || out_free;
  assign cnt_zero = cnt_r == '0;
  assign cnt_one  = cnt_r == CNT_W'(1);
  assign cnt_full = cnt_r == CNT_W'(STACK_DEPTH);
  assign top_prec = prec_of(rd_data_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[AW'(cnt_r)] <= cmd_r.sym;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    q_ready   = 1'b0;
    emit_req  = 1'b0;
    emit_sym  = '0;
    emit_sv   = 1'b0;
    emit_st   = ST_OK;
    wr_en     = 1'b0;
    fin_move  = 1'b0;
    fin_mark  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_ready   = 1'b1;
          cmd_nxt   = q_data;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (cmd_r.kind)
          K_LETTER: begin
            emit_req = 1'b1;
            emit_sym = cmd_r.sym;
            emit_sv  = 1'b1;
            if (can_emit) begin
              state_nxt = S_FLUSHCHK;
            end
          end
          K_OPEN:  state_nxt = S_PUSH;
          K_CLOSE: state_nxt = cnt_zero ? S_CLOSE_MARK : S_CLOSE_EVAL;
          default: state_nxt = cnt_zero ? S_PUSH : S_OP_EVAL;
        endcase
      end
      S_CLOSE_EVAL: begin
        if (rd_data_r == CH_OPEN) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_FLUSHCHK;
        end else begin
          emit_req = 1'b1;
          emit_sym = rd_data_r;
          emit_sv  = 1'b1;
          if (can_emit) begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = cnt_one ? S_CLOSE_MARK : S_CLOSE_WAIT;
          end
        end
      end
      S_CLOSE_WAIT: state_nxt = S_CLOSE_EVAL;
      S_CLOSE_MARK: begin
        emit_req = 1'b1;
        emit_st  = ST_NO_OPEN;
        if (can_emit) begin
          state_nxt = S_FLUSHCHK;
        end
      end
      S_OP_EVAL: begin
        if (top_prec >= cmd_r.prec) begin
          emit_req = 1'b1;
          emit_sym = rd_data_r;
          emit_sv  = 1'b1;
          if (can_emit) begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = cnt_one ? S_PUSH : S_OP_WAIT;
          end
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_OP_WAIT: state_nxt = S_OP_EVAL;
      S_PUSH: begin
        if (cnt_full) begin
          emit_req = 1'b1;
          emit_st  = ST_FULL;
          if (can_emit) begin
            state_nxt = S_FLUSHCHK;
          end
        end else begin
          wr_en     = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_FLUSHCHK;
        end
      end
      S_FLUSHCHK: state_nxt = (cmd_r.last && !cnt_zero) ? S_FLUSH_WAIT : S_FIN;
      S_FLUSH_WAIT: state_nxt = S_FLUSH_EVAL;
      S_FLUSH_EVAL: begin
        emit_req = 1'b1;
        emit_sym = rd_data_r;
        emit_sv  = 1'b1;
        if (can_emit) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = cnt_one ? S_FIN : S_FLUSH_WAIT;
        end
      end
      S_FIN: begin
        if (!pend_valid_r && !cmd_r.last) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          fin_move  = pend_valid_r;
          fin_mark  = !pend_valid_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign emit_fire     = emit_req && can_emit;
  assign out_load_pend = (emit_fire && pend_valid_r) || fin_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit_fire) begin
        pend_valid_r <= 1'b1;
      end else if (fin_move) begin
        pend_valid_r <= 1'b0;
      end
      if (out_load_pend || fin_mark) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      pend_sym_r <= emit_sym;
      pend_sv_r  <= emit_sv;
      pend_st_r  <= emit_st;
    end
    if (out_load_pend) begin
      out_sym_r   <= pend_sym_r;
      out_sv_r    <= pend_sv_r;
      out_st_r    <= pend_st_r;
      out_rlast_r <= fin_move;
      out_eend_r  <= fin_move && cmd_r.last;
    end else if (fin_mark) begin
      out_sym_r   <= '0;
      out_sv_r    <= 1'b0;
      out_st_r    <= ST_OK;
      out_rlast_r <= 1'b1;
      out_eend_r  <= 1'b1;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_sym       = out_sym_r;
  assign out_sym_valid = out_sv_r;
  assign out_run_last  = out_rlast_r;
  assign out_expr_end  = out_eend_r;
  assign out_status    = out_st_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_valid_r)
    else $error("result left pending between items");

  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && cmd_r.last) |-> cnt_r == '0)
    else $error("stack not empty after final flush");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eend_r) |-> out_rlast_r)
    else $error("expression end without run end");

  a_push_only_below_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("push did not advance stack count");

endmodule

// ===== rtl/infix_to_postfix_converter_core.sv =====
// Infix to postfix converter, shunting-yard scheme.
// Input stream: one ASCII character per transaction on in_tdata[7:0], in_tlast
// marking the final character of an expression. Result stream: zero or more
// postfix characters per input; out_tlast marks the last result caused by
// one input, out_tdata[8] the final result of the expression. Marker-only
// results (out_tuser[0] low) carry a status: close bracket without open, or
// stack full with the push dropped. A final character that yields nothing
// still gives one marker result, with status OK.
// A letter passes through the front, queue, command, pending and output
// registers. The sequencer finishes one item before taking the next and
// goes through a wait state between stack entries it pops (registered read).
// Input is taken into a register and a short command queue, so the front keeps
// accepting until the queue fills while the sequencer works or waits on output.
// When out_tready is low the pending and output registers hold and the
// sequencer stops at its next result; nothing is lost.
// Reset (rst_n low, synchronous) empties the stack, the queue and the front,
// pending and output registers; stack contents need no clearing.
module infix_to_postfix_converter_core
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] symbol_out, [8] expression_end
  output logic        out_tlast,
  output logic [2:0]  out_tuser   // [0] symbol_valid, [2:1] status
);

  logic       push_valid;
  logic       push_ready;
  cmd_t       push_data;
  logic       pop_valid;
  logic       pop_ready;
  cmd_t       pop_data;
  logic [7:0] res_sym;
  logic       res_sv;
  logic       res_eend;
  status_t    res_st;

  itp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_sym     (in_tdata),
    .in_last    (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  itp_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (pop_valid),
    .q_ready       (pop_ready),
    .q_data        (pop_data),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_sym       (res_sym),
    .out_sym_valid (res_sv),
    .out_run_last  (out_tlast),
    .out_expr_end  (res_eend),
    .out_status    (res_st)
  );

  assign out_tdata = {7'b0, res_eend, res_sym};
  assign out_tuser = {res_st, res_sv};

endmodule

// ===== tb/sv/tb_infix_to_postfix_converter_core.sv =====
module tb_infix_to_postfix_converter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  localparam int DEPTH          = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    logic [7:0] sym;
    logic       valid;
    logic       run_last;
    logic       expr_end;
    status_t    status;
  } postfix_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] symbol
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [7:0] symbol_out, [8] expression_end
  logic        out_tlast;
  logic [2:0]  out_tuser;           // [0] symbol_valid, [2:1] status

  postfix_result_t expected_postfix[$];
  postfix_result_t step_run[$];
  logic [7:0]      op_stack[DEPTH];
  int              op_count;
  logic [7:0]      expr_buf[$];

  int in_idle_pct     = 0;
  int out_idle_pct    = 0;
  int hold_requests   = 0;
  int hold_served     = 0;
  int hold_left       = 0;
  int items_sent      = 0;
  int expressions     = 0;
  int results_seen    = 0;
  int markers_seen    = 0;
  int errors          = 0;

  infix_to_postfix_converter_core #(.STACK_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int op_rank(input logic [7:0] c);
    if (c == CH_PLUS || c == CH_MINUS) return 1;
    if (c == CH_STAR || c == CH_SLASH) return 2;
    return 0;
  endfunction

  function automatic void add_result(input logic [7:0] s, input logic v, input status_t st);
    postfix_result_t r;
    r.sym      = s;
    r.valid    = v;
    r.run_last = 1'b0;
    r.expr_end = 1'b0;
    r.status   = st;
    step_run.push_back(r);
  endfunction

  function automatic void push_operator(input logic [7:0] c);
    if (op_count >= DEPTH) begin
      add_result(8'h00, 1'b0, ST_FULL);
    end else begin
      op_stack[op_count] = c;
      op_count++;
    end
  endfunction

  function automatic logic [7:0] pop_operator();
    op_count--;
    return op_stack[op_count];
  endfunction

  function automatic void convert_symbol(input logic [7:0] c, input logic last);
    logic [7:0] top;
    bit         found;
    int         rank;
    step_run.delete();
    if (c >= CH_A && c <= CH_Z) begin
      add_result(c, 1'b1, ST_OK);
    end else if (c == CH_OPEN) begin
      push_operator(c);
    end else if (c == CH_CLOSE) begin
      found = 0;
      while (op_count > 0 && !found) begin
        top = pop_operator();
        if (top == CH_OPEN) found = 1;
        else add_result(top, 1'b1, ST_OK);
      end
      if (!found) add_result(8'h00, 1'b0, ST_NO_OPEN);
    end else begin
      rank = op_rank(c);
      while (op_count > 0 && op_rank(op_stack[op_count-1]) >= rank)
        add_result(pop_operator(), 1'b1, ST_OK);
      push_operator(c);
    end
    if (last) begin
      while (op_count > 0) add_result(pop_operator(), 1'b1, ST_OK);
      if (step_run.size() == 0) add_result(8'h00, 1'b0, ST_OK);
      step_run[step_run.size()-1].expr_end = 1'b1;
    end
    if (step_run.size() > 0) step_run[step_run.size()-1].run_last = 1'b1;
    foreach (step_run[i]) expected_postfix.push_back(step_run[i]);
  endfunction

  task automatic send_symbol(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    convert_symbol(c, last);
    items_sent++;
  endtask

  task automatic send_buffer();
    foreach (expr_buf[i]) send_symbol(expr_buf[i], i == expr_buf.size() - 1);
    expressions++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    return CH_A + 8'($urandom_range(25));
  endfunction

  function automatic void build_expression(input int depth);
    int terms;
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) expr_buf.push_back(pick_operator());
      if (depth > 0 && $urandom_range(2) == 0) begin
        expr_buf.push_back(CH_OPEN);
        build_expression(depth - 1);
        expr_buf.push_back(CH_CLOSE);
      end else begin
        expr_buf.push_back(pick_letter());
      end
    end
  endfunction

  function automatic void build_broken();
    int len;
    if ($urandom_range(7) == 0) begin
      len = $urandom_range(12, 18);
      repeat (len) expr_buf.push_back(CH_OPEN);
    end
    len = $urandom_range(1, 12);
    repeat (len) begin
      case ($urandom_range(8))
        0, 1, 2: expr_buf.push_back(pick_letter());
        3, 4, 5: expr_buf.push_back(pick_operator());
        6:       expr_buf.push_back(CH_OPEN);
        7:       expr_buf.push_back(CH_CLOSE);
        default: expr_buf.push_back(8'($urandom_range(255)));
      endcase
    end
  endfunction

  task automatic send_random_expression();
    int pick;
    expr_buf.delete();
    pick = $urandom_range(9);
    if (pick < 7) begin
      build_expression($urandom_range(6));
    end else if (pick < 9) begin
      build_broken();
    end else begin
      repeat ($urandom_range(1, 4)) expr_buf.push_back(8'($urandom_range(255)));
    end
    send_buffer();
  endtask

  task automatic test_precedence_and_brackets();
    expr_buf = '{CH_A, CH_STAR, CH_A + 8'd1, CH_MINUS, CH_CLOSE, CH_OPEN, CH_CLOSE};
    send_buffer();
    expr_buf = '{CH_Z, CH_SLASH, CH_PLUS, 8'h00};
    send_buffer();
  endtask

  task automatic test_stack_overflow();
    expr_buf.delete();
    repeat (DEPTH + 1) expr_buf.push_back(CH_OPEN);
    expr_buf.push_back(8'hFF);
    send_buffer();
  endtask

  task automatic test_random_traffic(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_random_expression();
  endtask

  task automatic test_backpressure();
    int target;
    target = items_sent + 30;
    hold_requests++;
    while (items_sent < target) send_random_expression();
  endtask

  // receiver: random stalls, plus a long hold when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_tready  <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    postfix_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser[2:1] != ST_OK) markers_seen++;
      if (expected_postfix.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sym=%h valid=%b run_last=%b end=%b status=%0d",
                 $time, out_tdata[7:0], out_tuser[0], out_tlast, out_tdata[8],
                 out_tuser[2:1]);
      end else begin
        want = expected_postfix.pop_front();
        if (out_tdata[7:0] !== want.sym || out_tuser[0] !== want.valid ||
            out_tlast !== want.run_last || out_tdata[8] !== want.expr_end ||
            out_tuser[2:1] !== want.status) begin
          errors++;
          $display("%0t: mismatch expected sym=%h valid=%b run_last=%b end=%b status=%0d",
                   $time, want.sym, want.valid, want.run_last, want.expr_end,
                   want.status);
          $display("%0t:          actual   sym=%h valid=%b run_last=%b end=%b status=%0d",
                   $time, out_tdata[7:0], out_tuser[0], out_tlast, out_tdata[8],
                   out_tuser[2:1]);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    op_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    in_idle_pct  = 25;
    out_idle_pct = 80;
    test_precedence_and_brackets();
    test_stack_overflow();
    test_random_traffic(100);

    in_idle_pct  = 80;
    out_idle_pct = 25;
    test_random_traffic(100);

    in_idle_pct = 0;
    test_backpressure();

    out_idle_pct = 0;
    test_random_traffic(100);
    release_input();

    while (expected_postfix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d symbols in %0d expressions, %0d results checked",
             items_sent, expressions, results_seen);
    $display("Summary: %0d status markers, stack overflow and long output hold included",
             markers_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
